FILE: rtl/utf8d_pkg.sv
// Shared types and constants for the streaming UTF-8 decoder.
// Used by the interface file, the decode stage, the result queue and the top level.
// Depends on nothing.
package utf8d_pkg;

    // Field widths of the input and result items.
    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CNT_W  = 3;

    // One input item can cause at most this many result items.
    localparam int MAX_RES = 4;
    localparam int RES_N_W = 3;

    // Result queue geometry. The input side is open while the queue has room
    // for a full burst of results.
    localparam int QDEPTH  = 8;
    localparam int QPTR_W  = 3;
    localparam int QCNT_W  = 4;
    localparam logic [QCNT_W-1:0] QROOM_LIMIT = QCNT_W'(QDEPTH - MAX_RES);

    // Byte classes.
    localparam logic [7:0] ASCII_MASK  = 8'h80;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_CODE   = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;

    // Sequence lengths; zero means no sequence is open.
    localparam logic [CNT_W-1:0] LEN_IDLE = 3'd0;
    localparam logic [CNT_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [CNT_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [CNT_W-1:0] LEN_THREE = 3'd3;
    localparam logic [CNT_W-1:0] LEN_FOUR = 3'd4;

    // One result item.
    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [CNT_W-1:0] byte_count;
        logic             raw_fallback;
        logic             end_of_text;
    } result_t;

    // The burst of results caused by one accepted input item.
    typedef struct packed {
        logic [RES_N_W-1:0]          count;
        result_t [MAX_RES-1:0]       slot;
    } burst_t;

endpackage

FILE: rtl/utf8d_ifs.sv
// Handshake interfaces for the decoder: the byte input channel and the
// code point output channel. Depends on utf8d_pkg.
interface utf8d_byte_if;
    logic                           valid;
    logic                           ready;
    logic [utf8d_pkg::BYTE_W-1:0]   text_byte;
    logic                           last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface utf8d_cp_if;
    logic                           valid;
    logic                           ready;
    logic [utf8d_pkg::CP_W-1:0]     code_point;
    logic [utf8d_pkg::CNT_W-1:0]    byte_count;
    logic                           raw_fallback;
    logic                           end_of_text;

    modport source (output valid, output code_point, output byte_count,
                    output raw_fallback, output end_of_text, input ready);
    modport sink   (input valid, input code_point, input byte_count,
                    input raw_fallback, input end_of_text, output ready);
endinterface

FILE: rtl/utf8d_decode.sv
// Decode stage: sequence state registers and the single-pass byte decoder.
// Produces the burst of results for each accepted item. Depends on utf8d_pkg.
module utf8d_decode (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [utf8d_pkg::BYTE_W-1:0]  text_byte,
    input  logic                          last_byte,
    output utf8d_pkg::burst_t             burst
);

    // Open sequence state.
    logic [7:0]                     lead_reg, lead_next;
    logic [utf8d_pkg::CP_W-1:0]     partial_reg, partial_next;
    logic [utf8d_pkg::CNT_W-1:0]    exp_len_reg, exp_len_next;
    logic [utf8d_pkg::CNT_W-1:0]    gathered_reg, gathered_next;
    logic [7:0]                     cont_reg [2];
    logic [7:0]                     cont_next [2];

    logic                           is_cont;
    logic [utf8d_pkg::CNT_W-1:0]    gath_inc;
    logic [utf8d_pkg::CP_W-1:0]     assembled;
    logic [utf8d_pkg::RES_N_W-1:0]  res_n;
    logic [utf8d_pkg::RES_N_W-1:0]  res_last;
    utf8d_pkg::result_t [utf8d_pkg::MAX_RES-1:0] slot;

    function automatic utf8d_pkg::result_t mk_raw(input logic [7:0] b, input logic raw);
        utf8d_pkg::result_t r;
        r.code_point   = {{(utf8d_pkg::CP_W-8){1'b0}}, b};
        r.byte_count   = utf8d_pkg::LEN_ONE;
        r.raw_fallback = raw;
        r.end_of_text  = 1'b0;
        return r;
    endfunction

    assign is_cont   = (text_byte & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_CODE;
    assign gath_inc  = gathered_reg + 3'd1;
    assign assembled = {partial_reg[utf8d_pkg::CP_W-7:0], text_byte[5:0]};
    assign res_last  = res_n - 3'd1;

    // Handle one byte: continue, break or open a sequence, then flush at end of text.
    always_comb
    begin
        res_n         = '0;
        slot          = '0;
        lead_next     = lead_reg;
        partial_next  = partial_reg;
        exp_len_next  = exp_len_reg;
        gathered_next = gathered_reg;
        cont_next[0]  = cont_reg[0];
        cont_next[1]  = cont_reg[1];
        if (accept)
        begin
            if (exp_len_reg != utf8d_pkg::LEN_IDLE && is_cont)
            begin
                if (gath_inc >= exp_len_reg)
                begin
                    // Sequence complete: emit the assembled code point.
                    slot[res_n[1:0]].code_point   = assembled;
                    slot[res_n[1:0]].byte_count   = exp_len_reg;
                    slot[res_n[1:0]].raw_fallback = 1'b0;
                    res_n         = res_n + 3'd1;
                    lead_next     = '0;
                    partial_next  = '0;
                    exp_len_next  = utf8d_pkg::LEN_IDLE;
                    gathered_next = '0;
                end
                else
                begin
                    partial_next  = assembled;
                    gathered_next = gath_inc;
                    cont_next[gath_inc[0]] = text_byte;
                end
            end
            else
            begin
                // A non-continuation byte breaks an open sequence.
                if (exp_len_reg != utf8d_pkg::LEN_IDLE)
                begin
                    slot[res_n[1:0]] = mk_raw(lead_reg, 1'b1);
                    res_n = res_n + 3'd1;
                    if (gathered_reg >= utf8d_pkg::LEN_TWO)
                    begin
                        slot[res_n[1:0]] = mk_raw(cont_reg[0], 1'b1);
                        res_n = res_n + 3'd1;
                    end
                    if (gathered_reg >= utf8d_pkg::LEN_THREE)
                    begin
                        slot[res_n[1:0]] = mk_raw(cont_reg[1], 1'b1);
                        res_n = res_n + 3'd1;
                    end
                    lead_next     = '0;
                    partial_next  = '0;
                    exp_len_next  = utf8d_pkg::LEN_IDLE;
                    gathered_next = '0;
                end
                // The byte is then handled as if idle.
                if ((text_byte & utf8d_pkg::ASCII_MASK) == 8'h00)
                begin
                    slot[res_n[1:0]] = mk_raw(text_byte, 1'b0);
                    res_n = res_n + 3'd1;
                end
                else if ((text_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_CODE)
                begin
                    lead_next     = text_byte;
                    partial_next  = {{(utf8d_pkg::CP_W-5){1'b0}}, text_byte[4:0]};
                    exp_len_next  = utf8d_pkg::LEN_TWO;
                    gathered_next = utf8d_pkg::LEN_ONE;
                end
                else if ((text_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_CODE)
                begin
                    lead_next     = text_byte;
                    partial_next  = {{(utf8d_pkg::CP_W-4){1'b0}}, text_byte[3:0]};
                    exp_len_next  = utf8d_pkg::LEN_THREE;
                    gathered_next = utf8d_pkg::LEN_ONE;
                end
                else if ((text_byte & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_CODE)
                begin
                    lead_next     = text_byte;
                    partial_next  = {{(utf8d_pkg::CP_W-3){1'b0}}, text_byte[2:0]};
                    exp_len_next  = utf8d_pkg::LEN_FOUR;
                    gathered_next = utf8d_pkg::LEN_ONE;
                end
                else
                begin
                    slot[res_n[1:0]] = mk_raw(text_byte, 1'b1);
                    res_n = res_n + 3'd1;
                end
            end

            // The text ends inside a sequence: flush what is held.
            if (last_byte && exp_len_next != utf8d_pkg::LEN_IDLE)
            begin
                slot[res_n[1:0]] = mk_raw(lead_next, 1'b1);
                res_n = res_n + 3'd1;
                if (gathered_next >= utf8d_pkg::LEN_TWO)
                begin
                    slot[res_n[1:0]] = mk_raw(cont_next[0], 1'b1);
                    res_n = res_n + 3'd1;
                end
                if (gathered_next >= utf8d_pkg::LEN_THREE)
                begin
                    slot[res_n[1:0]] = mk_raw(cont_next[1], 1'b1);
                    res_n = res_n + 3'd1;
                end
                lead_next     = '0;
                partial_next  = '0;
                exp_len_next  = utf8d_pkg::LEN_IDLE;
                gathered_next = '0;
            end
        end
    end

    // Mark the final result of the text.
    always_comb
    begin
        burst.slot  = slot;
        burst.count = res_n;
        if (accept && last_byte && res_n != '0)
        begin
            burst.slot[res_last[1:0]].end_of_text = 1'b1;
        end
    end

    // Sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg     <= '0;
            partial_reg  <= '0;
            exp_len_reg  <= utf8d_pkg::LEN_IDLE;
            gathered_reg <= '0;
        end
        else
        begin
            lead_reg     <= lead_next;
            partial_reg  <= partial_next;
            exp_len_reg  <= exp_len_next;
            gathered_reg <= gathered_next;
        end
    end

    // Held continuation bytes carry no reset.
    always_ff @(posedge clk)
    begin
        cont_reg[0] <= cont_next[0];
        cont_reg[1] <= cont_next[1];
    end

    // A burst appears only for an accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> burst.count == '0)
        else $error("decode produced results without an accepted item");

    // The last byte of a text always produces at least one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |-> burst.count != '0)
        else $error("last byte produced no result");

    // After the last byte the decoder is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> exp_len_reg == utf8d_pkg::LEN_IDLE)
        else $error("sequence left open after end of text");

endmodule

FILE: rtl/utf8d_outq.sv
// Result queue: takes a burst of up to four results per cycle and hands them
// out one per cycle while char_out is ready. Depends on utf8d_pkg, utf8d_ifs.
module utf8d_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  utf8d_pkg::burst_t   burst,
    output logic                room,
    utf8d_cp_if.source          char_out
);

    utf8d_pkg::result_t             mem [utf8d_pkg::QDEPTH];
    logic [utf8d_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [utf8d_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [utf8d_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                           room_reg;
    logic                           pop;
    utf8d_pkg::result_t             head;

    assign pop  = char_out.valid && char_out.ready;
    assign room = room_reg;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + burst.count;
        rd_ptr_next = rd_ptr_reg + utf8d_pkg::QPTR_W'(pop);
        count_next  = count_reg + {1'b0, burst.count} - utf8d_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            room_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            room_reg   <= count_next <= utf8d_pkg::QROOM_LIMIT;
        end
    end

    // Burst write into consecutive entries.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < utf8d_pkg::MAX_RES; i++)
        begin
            if (utf8d_pkg::RES_N_W'(i) < burst.count)
            begin
                mem[wr_ptr_reg + utf8d_pkg::QPTR_W'(i)] <= burst.slot[i];
            end
        end
    end

    // Head of the queue drives the output channel.
    assign head                  = mem[rd_ptr_reg];
    assign char_out.valid        = count_reg != '0;
    assign char_out.code_point   = head.code_point;
    assign char_out.byte_count   = head.byte_count;
    assign char_out.raw_fallback = head.raw_fallback;
    assign char_out.end_of_text  = head.end_of_text;

    // The queue never overfills.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= utf8d_pkg::QCNT_W'(utf8d_pkg::QDEPTH))
        else $error("result queue overflow");

    // A burst arrives only while room was advertised.
    assert property (@(posedge clk) disable iff (!rst_n)
        burst.count != '0 |-> room_reg)
        else $error("burst written without room");

    // Fill level tracks writes and reads.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == $past(count_reg) + {1'b0, $past(burst.count)}
                     - utf8d_pkg::QCNT_W'($past(pop)))
        else $error("result queue fill count out of step");

endmodule

FILE: rtl/utf8_stream_decoder_unit.sv
// Top level of the streaming UTF-8 decoder.
// Depends on utf8d_pkg, utf8d_ifs, utf8d_decode and utf8d_outq.
//
// Usage:
// text_in carries one text byte per item with a last_byte flag that closes
// the text. char_out carries one decoded character per item: code point,
// input bytes consumed, a raw-fallback flag and an end-of-text flag on the
// final character of a text.
// A byte is decoded in the cycle it is accepted; its results are queued
// for char_out. One byte is accepted per cycle while text_in.ready is high.
// A broken or unfinished sequence releases up to four results for one byte;
// they leave one per cycle from an eight-entry result queue, and
// text_in.ready drops while fewer than four entries are free.
// When the receiver stalls, the queue holds its items and fills; input is
// then held off until room for a full burst returns.
// During reset text_in.ready is low and char_out.valid is low; after reset
// the decoder is idle with an empty queue and no clearing pass.
module utf8_stream_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    utf8d_byte_if.sink  text_in,
    utf8d_cp_if.source  char_out
);

    logic               room;
    logic               accept;
    utf8d_pkg::burst_t  burst;

    assign text_in.ready = room;
    assign accept        = text_in.valid && room;

    // Byte decoder with sequence state.
    utf8d_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_in.text_byte),
        .last_byte (text_in.last_byte),
        .burst     (burst)
    );

    // Result queue and output channel.
    utf8d_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .burst    (burst),
        .room     (room),
        .char_out (char_out)
    );

endmodule

FILE: sim/tb_utf8_stream_decoder_unit.sv
// Self-checking testbench for the streaming UTF-8 decoder top level.
// Depends on utf8d_pkg, the utf8d_ifs interfaces and utf8_stream_decoder_unit.
// A built-in decoder predicts every character; a checker compares each one.
module tb_utf8_stream_decoder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    // Ways the receiver can behave; each lasts a random stretch of cycles.
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BLOCKS} sink_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    utf8d_byte_if text_in();
    utf8d_cp_if   char_out();

    utf8_stream_decoder_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .char_out (char_out)
    );

    always #6 clk = ~clk;

    // Decoder state as the predictor sees it.
    logic [utf8d_pkg::BYTE_W-1:0] lead_reg;
    logic [utf8d_pkg::CP_W-1:0]   acc_cp;
    logic [utf8d_pkg::CNT_W-1:0]  seq_len;
    logic [utf8d_pkg::CNT_W-1:0]  seq_cnt;
    logic [utf8d_pkg::BYTE_W-1:0] cont_hold [2];

    // Characters predicted but not yet seen on the output.
    utf8d_pkg::result_t exp_chars [$];
    utf8d_pkg::result_t want;

    int errors      = 0;
    int burst_left  = 0;
    int n_bytes     = 0;
    int n_multi     = 0;
    int n_raw       = 0;
    int n_texts     = 0;
    int n_chars     = 0;

    sink_mode_t sink_mode  = SINK_OPEN;
    int         sink_left  = 0;
    int         stall_left = 0;

    // Predictor.

    function automatic void push_char(input logic [utf8d_pkg::CP_W-1:0] cp,
                                      input logic [utf8d_pkg::CNT_W-1:0] cnt,
                                      input logic raw);
        utf8d_pkg::result_t r;
        r.code_point   = cp;
        r.byte_count   = cnt;
        r.raw_fallback = raw;
        r.end_of_text  = 1'b0;
        exp_chars.push_back(r);
    endfunction

    function automatic void clear_seq();
        lead_reg = '0;
        acc_cp   = '0;
        seq_len  = utf8d_pkg::LEN_IDLE;
        seq_cnt  = utf8d_pkg::LEN_IDLE;
    endfunction

    // The lead and every held continuation come out as raw bytes.
    function automatic void flush_held();
        push_char(utf8d_pkg::CP_W'(lead_reg), utf8d_pkg::LEN_ONE, 1'b1);
        for (int i = 0; i < 2; i++)
        begin
            if (i + 1 < seq_cnt)
                push_char(utf8d_pkg::CP_W'(cont_hold[i]), utf8d_pkg::LEN_ONE, 1'b1);
        end
        clear_seq();
    endfunction

    // Handles a byte met while no sequence is open.
    function automatic void start_char(input logic [utf8d_pkg::BYTE_W-1:0] b);
        if ((b & utf8d_pkg::ASCII_MASK) == '0)
            push_char(utf8d_pkg::CP_W'(b), utf8d_pkg::LEN_ONE, 1'b0);
        else if ((b & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_CODE)
        begin
            lead_reg = b;
            acc_cp   = utf8d_pkg::CP_W'(b & ~utf8d_pkg::LEAD2_MASK);
            seq_len  = utf8d_pkg::LEN_TWO;
            seq_cnt  = utf8d_pkg::LEN_ONE;
        end
        else if ((b & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_CODE)
        begin
            lead_reg = b;
            acc_cp   = utf8d_pkg::CP_W'(b & ~utf8d_pkg::LEAD3_MASK);
            seq_len  = utf8d_pkg::LEN_THREE;
            seq_cnt  = utf8d_pkg::LEN_ONE;
        end
        else if ((b & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_CODE)
        begin
            lead_reg = b;
            acc_cp   = utf8d_pkg::CP_W'(b & ~utf8d_pkg::LEAD4_MASK);
            seq_len  = utf8d_pkg::LEN_FOUR;
            seq_cnt  = utf8d_pkg::LEN_ONE;
        end
        else
            push_char(utf8d_pkg::CP_W'(b), utf8d_pkg::LEN_ONE, 1'b1);
    endfunction

    function automatic void predict_byte(input logic [utf8d_pkg::BYTE_W-1:0] b,
                                         input logic last);
        int n_prior;
        n_prior = exp_chars.size();
        if (seq_len != utf8d_pkg::LEN_IDLE)
        begin
            if ((b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_CODE)
            begin
                acc_cp  = {acc_cp[utf8d_pkg::CP_W-7:0], b[5:0]};
                seq_cnt = seq_cnt + 1'b1;
                if (seq_cnt >= seq_len)
                begin
                    push_char(acc_cp, seq_len, 1'b0);
                    clear_seq();
                end
                else
                    cont_hold[1'(seq_cnt - utf8d_pkg::LEN_TWO)] = b;
            end
            else
            begin
                flush_held();
                start_char(b);
            end
        end
        else
            start_char(b);

        // The end of the text flushes an open sequence and marks the last character.
        if (last && seq_len != utf8d_pkg::LEN_IDLE)
            flush_held();
        if (last && exp_chars.size() > n_prior)
            exp_chars[exp_chars.size() - 1].end_of_text = 1'b1;
    endfunction

    // Byte generators.

    function automatic logic [utf8d_pkg::BYTE_W-1:0] lead_byte(input int len);
        logic [utf8d_pkg::BYTE_W-1:0] b;
        b = utf8d_pkg::BYTE_W'($urandom);
        case (len)
            utf8d_pkg::LEN_TWO:
                b = utf8d_pkg::LEAD2_CODE | (b & ~utf8d_pkg::LEAD2_MASK);
            utf8d_pkg::LEN_THREE:
                b = utf8d_pkg::LEAD3_CODE | (b & ~utf8d_pkg::LEAD3_MASK);
            default:
                b = utf8d_pkg::LEAD4_CODE | (b & ~utf8d_pkg::LEAD4_MASK);
        endcase
        return b;
    endfunction

    function automatic logic [utf8d_pkg::BYTE_W-1:0] cont_byte();
        return utf8d_pkg::CONT_CODE
               | (utf8d_pkg::BYTE_W'($urandom) & ~utf8d_pkg::CONT_MASK);
    endfunction

    // Sender: bursts of random length, random gaps between them.

    task automatic send_byte(input logic [utf8d_pkg::BYTE_W-1:0] b, input logic last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                text_in.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
        end
        text_in.valid     <= 1'b1;
        text_in.text_byte <= b;
        text_in.last_byte <= last;
        do @(posedge clk); while (!text_in.ready);
        predict_byte(b, last);
        n_bytes++;
        burst_left--;
        @(negedge clk);
    endtask

    // Holds the input off until every predicted character has arrived.
    task automatic wait_drained();
        text_in.valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (exp_chars.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    // Receiver: switches between random stall patterns.
    always @(negedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            sink_left = $urandom_range(20, 80);
        end
        sink_left--;
        case (sink_mode)
            SINK_OPEN:   char_out.ready <= 1'b1;
            SINK_COIN:   char_out.ready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: char_out.ready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_left != 0)
                begin
                    char_out.ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    char_out.ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(4, 14);
                end
            end
        endcase
    end

    // Checker: each accepted character against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && char_out.valid && char_out.ready)
        begin
            if (exp_chars.size() == 0)
            begin
                errors++;
                $display({"%0t: unexpected character: expected none, ",
                          "got cp=%h cnt=%0d raw=%b eot=%b"},
                         $time, char_out.code_point, char_out.byte_count,
                         char_out.raw_fallback, char_out.end_of_text);
            end
            else
            begin
                want = exp_chars.pop_front();
                if (char_out.code_point !== want.code_point
                    || char_out.byte_count !== want.byte_count
                    || char_out.raw_fallback !== want.raw_fallback
                    || char_out.end_of_text !== want.end_of_text)
                begin
                    errors++;
                    $display({"%0t: mismatch: expected cp=%h cnt=%0d raw=%b eot=%b, ",
                              "got cp=%h cnt=%0d raw=%b eot=%b"},
                             $time, want.code_point, want.byte_count, want.raw_fallback,
                             want.end_of_text, char_out.code_point, char_out.byte_count,
                             char_out.raw_fallback, char_out.end_of_text);
                end
            end
            n_chars++;
            if (char_out.raw_fallback)
                n_raw++;
            if (char_out.byte_count > utf8d_pkg::LEN_ONE)
                n_multi++;
            if (char_out.end_of_text)
                n_texts++;
        end
    end

    // Tests.

    task automatic test_plain_bytes();
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_full_sequences();
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Largest value the four-byte form can carry.
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_invalid_leads();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_broken_sequences();
        // A plain byte breaks a three-byte sequence.
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
        // A new lead breaks a four-byte sequence and then completes itself.
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
    endtask

    task automatic test_end_of_text();
        // The text ends on a lone lead.
        send_byte(8'hDF, 1'b1);
        // An invalid byte breaks a sequence on the last byte: four characters at once.
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Mostly well-formed characters with random content, some truncated ones and noise.
    task automatic test_random_text(input int n_items);
        int sent;
        int kind;
        int len;
        int n_cont;
        logic [utf8d_pkg::BYTE_W-1:0] chunk [$];
        sent = 0;
        while (sent < n_items)
        begin
            chunk.delete();
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                len = $urandom_range(2, 4);
                chunk.push_back(lead_byte(len));
                repeat (len - 1) chunk.push_back(cont_byte());
            end
            else if (kind < 65)
                chunk.push_back(utf8d_pkg::BYTE_W'($urandom_range(1, 127)));
            else if (kind < 80)
            begin
                len    = $urandom_range(2, 4);
                n_cont = $urandom_range(0, len - 2);
                chunk.push_back(lead_byte(len));
                repeat (n_cont) chunk.push_back(cont_byte());
            end
            else if (kind < 90)
                chunk.push_back(utf8d_pkg::BYTE_W'($urandom_range(1, 255)));
            else if (kind < 95)
                chunk.push_back(cont_byte());
            else
                chunk.push_back(utf8d_pkg::BYTE_W'($urandom_range(8'hF8, 8'hFF)));

            foreach (chunk[i])
            begin
                send_byte(chunk[i], $urandom_range(0, 24) == 0);
                sent++;
            end
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end
    endtask

    // Main sequence.
    initial
    begin
        int drain_wait;
        rst_n              = 1'b0;
        text_in.valid      = 1'b0;
        text_in.text_byte  = '0;
        text_in.last_byte  = 1'b0;
        char_out.ready     = 1'b0;
        clear_seq();
        cont_hold[0] = '0;
        cont_hold[1] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_plain_bytes();
        test_full_sequences();
        wait_drained();
        test_invalid_leads();
        test_broken_sequences();
        test_end_of_text();
        wait_drained();
        test_random_text(145);

        // Let the last characters arrive, then watch for strays.
        text_in.valid <= 1'b0;
        drain_wait = 0;
        while (exp_chars.size() != 0 && drain_wait < 5000)
        begin
            @(negedge clk);
            drain_wait++;
        end
        repeat (8) @(negedge clk);
        if (exp_chars.size() != 0)
        begin
            errors++;
            $display("%0t: %0d predicted characters never arrived", $time, exp_chars.size());
        end

        $display("Sent %0d bytes; received %0d characters, %0d multi-byte,",
                 n_bytes, n_chars, n_multi);
        $display("%0d raw, %0d text ends, under bursty input and a stalling receiver.",
                 n_raw, n_texts);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
